// ----- src/qrd_rls_adaptive_fir_core_defines.svh -----
// assertion macros used by the checker file
`ifndef QRD_RLS_ADAPTIVE_FIR_CORE_DEFINES_SVH
`define QRD_RLS_ADAPTIVE_FIR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define QRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qrd check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define QRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qrd check failed");

`endif

// ----- src/qrd_pkg.sv -----
// types, constants and arithmetic helpers of the qrd-rls filter
`default_nettype none

package qrd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 25;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LAMBDA = 3'd0,
    CFG_DELTA  = 3'd1,
    CFG_SKIP   = 3'd2,
    CFG_ADAPT  = 3'd3,
    CFG_DECIM  = 3'd4
  } cfg_idx_e;

  localparam logic [16:0] LambdaReset = 17'd64881;
  localparam logic [16:0] LambdaMax   = 17'd65536;
  localparam logic [24:0] DeltaReset  = 25'd65536;
  localparam logic [24:0] DeltaMax    = 25'd19660800;
  localparam logic [8:0]  DecimMax    = 9'd256;
  localparam logic [16:0] SkipCntMax  = 17'h1ffff;

  localparam logic signed [31:0] Max32 = 32'sh7fffffff;
  localparam logic signed [31:0] Min32 = 32'sh80000000;
  localparam logic signed [31:0] One16 = 32'sd65536;

  typedef struct packed {
    logic               op;
    logic signed [31:0] sample;
    logic signed [31:0] desired;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] filtered_output;
    logic signed [31:0] error_output;
  } out_beat_t;

  typedef struct packed {
    logic        start;
    logic        sqrt_sel;
    logic [63:0] rad;
    logic [47:0] num;
    logic [31:0] den;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
    logic [47:0] quo;
  } arith_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return Max32;
    end else if (v < lo) begin
      return Min32;
    end
    return v[31:0];
  endfunction

  // round half up, drop 16 fraction bits
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    return v[31] ? n : v;
  endfunction

endpackage

`default_nettype wire

// ----- src/qrd_ram.sv -----
// single-port-write, single-port-read synchronous ram, registered read
`default_nettype none

module qrd_ram #(
  parameter int unsigned DataW = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [DataW-1:0]                           wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [DataW-1:0]                           rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/qrd_arith.sv -----
// shared iterative unit: integer square root and unsigned division
`default_nettype none

module qrd_arith (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire qrd_pkg::arith_req_t req_i,
  output qrd_pkg::arith_rsp_t      rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic        sqrt_q;
  logic [5:0]  cnt_q;
  logic [63:0] wk_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [31:0] den_q;

  logic [35:0] sq_sh;
  logic [35:0] sq_trial;
  logic        sq_ge;
  logic [32:0] dv_sh;
  logic        dv_ge;

  always_comb begin
    sq_sh    = {rem_q, wk_q[63:62]};
    sq_trial = {2'b00, root_q, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    dv_sh    = {rem_q[31:0], wk_q[47]};
    dv_ge    = dv_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.sqrt_sel ? 6'd31 : 6'd47;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.sqrt_sel;
      wk_q   <= req_i.sqrt_sel ? req_i.rad : {16'd0, req_i.num};
      den_q  <= req_i.den;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      if (sqrt_q) begin
        rem_q  <= sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
        root_q <= {root_q[30:0], sq_ge};
        wk_q   <= {wk_q[61:0], 2'b00};
      end else begin
        rem_q  <= {2'b00, (dv_ge ? 32'(dv_sh - {1'b0, den_q}) : dv_sh[31:0])};
        wk_q   <= {wk_q[62:0], dv_ge};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;
  assign rsp_o.quo  = wk_q[47:0];

endmodule

`default_nettype wire

// ----- src/qrd_rls_adaptive_fir_core.sv -----
// qrd-rls adaptive fir filter: sequencer, vectors and datapath around the matrix ram
//
// Input channel in_valid_i/in_ready_o carries one beat per sample or restart
// (op = 1). Output channel out_valid_o/out_ready_i carries filtered output
// and error, one beat for every decimation_factor-th sample.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i),
// written while the filter is idle: a rule for the user, not enforced by the core.
// One beat is worked at a time. A result with an RLS update takes longest:
// its time is set by the shared root/divide unit (up to four calls per tap,
// a root and two quotients in the rotation and one quotient in the back
// substitution, plus a root of lambda per update) and by the one matrix
// ram port.
// After reset and after every restart the matrix ram is swept, one entry a
// cycle over all NUM_TAPS*NUM_TAPS entries, with in_ready_o low.
// A finished result sits in the output register; the next input beat is
// taken while it waits, and a further result waits until out_ready_i frees it.
`default_nettype none

module qrd_rls_adaptive_fir_core #(
  parameter int unsigned NUM_TAPS = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire qrd_pkg::in_beat_t                  in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output qrd_pkg::out_beat_t                      out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [qrd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [qrd_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  localparam int unsigned N     = NUM_TAPS;
  localparam int unsigned Depth = N * N;
  localparam int unsigned IW    = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(N - 1);
  localparam logic [AW-1:0] RowLen  = AW'(N);
  localparam logic [AW-1:0] LastAdr = AW'(Depth - 1);

  typedef enum logic [37:0] {
    S_CLEAR   = 38'd1 << 0,
    S_IDLE    = 38'd1 << 1,
    S_SQL     = 38'd1 << 2,
    S_SC_RD   = 38'd1 << 3,
    S_SC_MUL  = 38'd1 << 4,
    S_SC_WR   = 38'd1 << 5,
    S_SD_MUL  = 38'd1 << 6,
    S_SD_WR   = 38'd1 << 7,
    S_ROT_RD  = 38'd1 << 8,
    S_ROT_U   = 38'd1 << 9,
    S_ROT_XX  = 38'd1 << 10,
    S_ROT_UU  = 38'd1 << 11,
    S_ROT_H   = 38'd1 << 12,
    S_ROT_C   = 38'd1 << 13,
    S_ROT_S   = 38'd1 << 14,
    S_ROT_D0  = 38'd1 << 15,
    S_ROT_D1  = 38'd1 << 16,
    S_ROT_D2  = 38'd1 << 17,
    S_OFF_RD  = 38'd1 << 18,
    S_OFF_M0  = 38'd1 << 19,
    S_OFF_M1  = 38'd1 << 20,
    S_OFF_M2  = 38'd1 << 21,
    S_OFF_M3  = 38'd1 << 22,
    S_OFF_M4  = 38'd1 << 23,
    S_RD_M0   = 38'd1 << 24,
    S_RD_M1   = 38'd1 << 25,
    S_RD_M2   = 38'd1 << 26,
    S_RD_M3   = 38'd1 << 27,
    S_RD_M4   = 38'd1 << 28,
    S_BS_RD   = 38'd1 << 29,
    S_BS_MUL  = 38'd1 << 30,
    S_BS_ACC  = 38'd1 << 31,
    S_BS_DRD  = 38'd1 << 32,
    S_BS_DIV  = 38'd1 << 33,
    S_BS_WAIT = 38'd1 << 34,
    S_FIR_MUL = 38'd1 << 35,
    S_FIR_ACC = 38'd1 << 36,
    S_OUT     = 38'd1 << 37
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [16:0] lam_q;
  logic [24:0] dreg_q;
  logic [15:0] skip_q;
  logic        adapt_q;
  logic [8:0]  decim_q;

  logic [24:0] delta_q;
  logic [7:0]  phase_q;
  logic [16:0] skcnt_q;

  logic signed [31:0] win_q [N];
  logic signed [31:0] x_q   [N];
  logic signed [31:0] rd_q  [N];
  logic signed [31:0] tap_q [N];
  logic signed [31:0] win_next [N];

  logic signed [31:0] des_q, d_q, u_q, um_q, c_q, s_q, sl_q;
  logic [31:0]        h_q;
  logic [63:0]        hsum_q;
  logic signed [63:0] p_q, acc_q, acc2_q;
  logic               bs_neg_q;

  logic [IW-1:0] n_q, m_q, clr_row_q, clr_col_q;
  logic [AW-1:0] sc_q;

  qrd_pkg::out_beat_t out_q;
  logic               out_valid_q;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  qrd_pkg::arith_req_t arq;
  qrd_pkg::arith_rsp_t ars;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] rm;

  logic               accept, produce, do_update, out_free;
  logic [16:0]        lam_c;
  logic [24:0]        delta_c;
  logic [8:0]         dec_c, phase_inc;
  logic [IW-1:0]      r_idx, bs_tidx;
  logic [AW-1:0]      a_diag, a_off, a_bs, a_bsd, a_clr;
  logic signed [31:0] xn, xm, rd_r, tap_bs, bs_num, bs_den, y, bs_q32, sq32;
  logic signed [63:0] bs_num64;
  logic [31:0]        xn_abs, u_abs, num_abs;
  logic               diag_clr, clr_last, last_n;

  qrd_ram #(
    .DataW(32),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  qrd_arith u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (arq),
    .rsp_o (ars)
  );

  for (genvar g = 0; g < N; g++) begin : g_win
    if (g < N - 1) begin : g_mid
      assign win_next[g] = win_q[g+1];
    end else begin : g_top
      assign win_next[g] = in_data_i.sample;
    end
  end

  always_comb begin
    lam_c   = (lam_q == 17'd0) ? 17'd1 :
              ((lam_q > qrd_pkg::LambdaMax) ? qrd_pkg::LambdaMax : lam_q);
    delta_c = (dreg_q == 25'd0) ? 25'd1 :
              ((dreg_q > qrd_pkg::DeltaMax) ? qrd_pkg::DeltaMax : dreg_q);
    dec_c   = (decim_q == 9'd0) ? 9'd1 :
              ((decim_q > qrd_pkg::DecimMax) ? qrd_pkg::DecimMax : decim_q);
    phase_inc = {1'b0, phase_q} + 9'd1;
    produce   = phase_q == 8'd0;
    do_update = adapt_q && ((skip_q == 16'd0) || (skcnt_q >= (17'(skip_q) + 17'd1)));
    accept    = in_valid_i && (state_q == S_IDLE);
    out_free  = !out_valid_q || out_ready_i;

    r_idx   = LastIdx - n_q;
    bs_tidx = LastIdx - m_q;
    last_n  = n_q == LastIdx;
    a_diag  = AW'(r_idx) * RowLen + AW'(n_q);
    a_off   = AW'(r_idx) * RowLen + AW'(m_q);
    a_bs    = AW'(n_q) * RowLen + AW'(bs_tidx);
    a_bsd   = AW'(n_q) * RowLen + AW'(r_idx);
    a_clr   = AW'(clr_row_q) * RowLen + AW'(clr_col_q);
    diag_clr = ({1'b0, clr_row_q} + {1'b0, clr_col_q}) == {1'b0, LastIdx};
    clr_last = (clr_row_q == LastIdx) && (clr_col_q == LastIdx);

    xn     = x_q[n_q];
    xm     = x_q[m_q];
    rd_r   = rd_q[r_idx];
    tap_bs = tap_q[bs_tidx];
    xn_abs = qrd_pkg::abs32(xn);
    u_abs  = qrd_pkg::abs32(u_q);

    bs_num64 = 64'(rd_q[n_q]) - acc_q;
    bs_num   = qrd_pkg::sat32(bs_num64);
    bs_den   = ram_rdata;
    num_abs  = qrd_pkg::abs32(bs_num);

    rm = qrd_pkg::rnd16(p_q);
    y  = qrd_pkg::sat32(acc_q);

    if (bs_neg_q) begin
      bs_q32 = (ars.quo > 48'h80000000) ? qrd_pkg::Min32 : -$signed(ars.quo[31:0]);
    end else begin
      bs_q32 = (ars.quo > 48'h7fffffff) ? qrd_pkg::Max32 : $signed(ars.quo[31:0]);
    end
    sq32 = $signed(ars.quo[31:0]);
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SC_MUL:  begin mul_a = sl_q;     mul_b = ram_rdata; end
      S_SD_MUL:  begin mul_a = sl_q;     mul_b = rd_q[m_q]; end
      S_ROT_U:   begin mul_a = xn;       mul_b = xn;        end
      S_ROT_XX:  begin mul_a = u_q;      mul_b = u_q;       end
      S_ROT_D0:  begin mul_a = s_q;      mul_b = xn;        end
      S_ROT_D1:  begin mul_a = c_q;      mul_b = u_q;       end
      S_OFF_M0:  begin mul_a = c_q;      mul_b = xm;        end
      S_OFF_M1:  begin mul_a = s_q;      mul_b = um_q;      end
      S_OFF_M2:  begin mul_a = s_q;      mul_b = xm;        end
      S_OFF_M3:  begin mul_a = c_q;      mul_b = um_q;      end
      S_RD_M0:   begin mul_a = c_q;      mul_b = d_q;       end
      S_RD_M1:   begin mul_a = s_q;      mul_b = rd_r;      end
      S_RD_M2:   begin mul_a = s_q;      mul_b = d_q;       end
      S_RD_M3:   begin mul_a = c_q;      mul_b = rd_r;      end
      S_BS_MUL:  begin mul_a = ram_rdata; mul_b = tap_bs;   end
      S_FIR_MUL: begin mul_a = tap_q[m_q]; mul_b = win_q[m_q]; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ram access and arithmetic unit requests
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    arq       = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = a_clr;
        ram_wdata = diag_clr ? 32'(delta_q) : 32'd0;
      end
      S_IDLE: begin
        if (accept && !in_data_i.op && produce && do_update) begin
          arq.start    = 1'b1;
          arq.sqrt_sel = 1'b1;
          arq.rad      = 64'(lam_c) << 16;
        end
      end
      S_SC_RD:  ram_raddr = sc_q;
      S_SC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sc_q;
        ram_wdata = qrd_pkg::sat32(rm);
      end
      S_ROT_RD: ram_raddr = a_diag;
      S_ROT_UU: begin
        arq.start    = 1'b1;
        arq.sqrt_sel = 1'b1;
        arq.rad      = hsum_q + 64'(p_q);
      end
      S_ROT_H: begin
        if (ars.done && (ars.root != 32'd0)) begin
          arq.start = 1'b1;
          arq.num   = {u_abs, 16'd0};
          arq.den   = ars.root;
        end
      end
      S_ROT_C: begin
        if (ars.done) begin
          arq.start = 1'b1;
          arq.num   = {xn_abs, 16'd0};
          arq.den   = h_q;
        end
      end
      S_ROT_D2: begin
        ram_we    = 1'b1;
        ram_waddr = a_diag;
        ram_wdata = qrd_pkg::sat32(acc_q + rm);
      end
      S_OFF_RD: ram_raddr = a_off;
      S_OFF_M4: begin
        ram_we    = 1'b1;
        ram_waddr = a_off;
        ram_wdata = qrd_pkg::sat32(acc2_q + rm);
      end
      S_BS_RD:  ram_raddr = a_bs;
      S_BS_DRD: ram_raddr = a_bsd;
      S_BS_DIV: begin
        if (bs_den != 32'sd0) begin
          arq.start = 1'b1;
          arq.num   = {num_abs, 16'd0};
          arq.den   = qrd_pkg::abs32(bs_den);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.op) begin
            state_d = S_CLEAR;
          end else if (produce) begin
            state_d = do_update ? S_SQL : S_FIR_MUL;
          end
        end
      end
      S_SQL:     if (ars.done) state_d = S_SC_RD;
      S_SC_RD:   state_d = S_SC_MUL;
      S_SC_MUL:  state_d = S_SC_WR;
      S_SC_WR:   state_d = (sc_q == LastAdr) ? S_SD_MUL : S_SC_RD;
      S_SD_MUL:  state_d = S_SD_WR;
      S_SD_WR:   state_d = (m_q == LastIdx) ? S_ROT_RD : S_SD_MUL;
      S_ROT_RD:  state_d = S_ROT_U;
      S_ROT_U:   state_d = S_ROT_XX;
      S_ROT_XX:  state_d = S_ROT_UU;
      S_ROT_UU:  state_d = S_ROT_H;
      S_ROT_H: begin
        if (ars.done) state_d = (ars.root == 32'd0) ? S_ROT_D0 : S_ROT_C;
      end
      S_ROT_C:   if (ars.done) state_d = S_ROT_S;
      S_ROT_S:   if (ars.done) state_d = S_ROT_D0;
      S_ROT_D0:  state_d = S_ROT_D1;
      S_ROT_D1:  state_d = S_ROT_D2;
      S_ROT_D2:  state_d = last_n ? S_RD_M0 : S_OFF_RD;
      S_OFF_RD:  state_d = S_OFF_M0;
      S_OFF_M0:  state_d = S_OFF_M1;
      S_OFF_M1:  state_d = S_OFF_M2;
      S_OFF_M2:  state_d = S_OFF_M3;
      S_OFF_M3:  state_d = S_OFF_M4;
      S_OFF_M4:  state_d = (m_q == LastIdx) ? S_RD_M0 : S_OFF_RD;
      S_RD_M0:   state_d = S_RD_M1;
      S_RD_M1:   state_d = S_RD_M2;
      S_RD_M2:   state_d = S_RD_M3;
      S_RD_M3:   state_d = S_RD_M4;
      S_RD_M4:   state_d = (n_q == '0) ? S_BS_DRD : S_BS_RD;
      S_BS_RD:   state_d = S_BS_MUL;
      S_BS_MUL:  state_d = S_BS_ACC;
      S_BS_ACC: begin
        state_d = (({1'b0, m_q} + 1'b1) == {1'b0, n_q}) ? S_BS_DRD : S_BS_RD;
      end
      S_BS_DRD:  state_d = S_BS_DIV;
      S_BS_DIV: begin
        if (bs_den != 32'sd0) begin
          state_d = S_BS_WAIT;
        end else begin
          state_d = last_n ? S_FIR_MUL : S_ROT_RD;
        end
      end
      S_BS_WAIT: if (ars.done) state_d = last_n ? S_FIR_MUL : S_ROT_RD;
      S_FIR_MUL: state_d = S_FIR_ACC;
      S_FIR_ACC: state_d = (m_q == LastIdx) ? S_OUT : S_FIR_MUL;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      lam_q       <= qrd_pkg::LambdaReset;
      dreg_q      <= qrd_pkg::DeltaReset;
      skip_q      <= '0;
      adapt_q     <= 1'b1;
      decim_q     <= 9'd1;
      delta_q     <= qrd_pkg::DeltaReset;
      phase_q     <= '0;
      skcnt_q     <= '0;
      clr_row_q   <= '0;
      clr_col_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        win_q[i] <= '0;
        rd_q[i]  <= '0;
        tap_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          qrd_pkg::CFG_LAMBDA: lam_q   <= cfg_wdata_i[16:0];
          qrd_pkg::CFG_DELTA:  dreg_q  <= cfg_wdata_i;
          qrd_pkg::CFG_SKIP:   skip_q  <= cfg_wdata_i[15:0];
          qrd_pkg::CFG_ADAPT:  adapt_q <= cfg_wdata_i[0];
          qrd_pkg::CFG_DECIM:  decim_q <= cfg_wdata_i[8:0];
          default: begin
            lam_q <= lam_q;
          end
        endcase
      end

      if (state_q == S_CLEAR) begin
        if (clr_col_q == LastIdx) begin
          clr_col_q <= '0;
          clr_row_q <= clr_last ? '0 : clr_row_q + 1'b1;
        end else begin
          clr_col_q <= clr_col_q + 1'b1;
        end
      end

      if (accept) begin
        if (in_data_i.op) begin
          delta_q <= delta_c;
          for (int i = 0; i < N; i++) begin
            rd_q[i]  <= '0;
            tap_q[i] <= '0;
          end
        end else begin
          for (int i = 0; i < N; i++) begin
            win_q[i] <= win_next[i];
          end
          phase_q <= (phase_inc >= dec_c) ? 8'd0 : phase_inc[7:0];
          if (produce) begin
            if (do_update) begin
              skcnt_q <= '0;
            end else if (skcnt_q != qrd_pkg::SkipCntMax) begin
              skcnt_q <= skcnt_q + 17'd1;
            end
          end
        end
      end

      if ((state_q == S_SD_WR)) begin
        rd_q[m_q] <= qrd_pkg::sat32(rm);
      end
      if (state_q == S_RD_M4) begin
        rd_q[r_idx] <= qrd_pkg::sat32(acc2_q + rm);
      end
      if ((state_q == S_BS_DIV) && (bs_den == 32'sd0)) begin
        tap_q[r_idx] <= (bs_num > 32'sd0) ? qrd_pkg::Max32 :
                        ((bs_num < 32'sd0) ? qrd_pkg::Min32 : 32'sd0);
      end
      if ((state_q == S_BS_WAIT) && ars.done) begin
        tap_q[r_idx] <= bs_q32;
      end

      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        acc_q <= '0;
        m_q   <= '0;
        des_q <= in_data_i.desired;
        d_q   <= in_data_i.desired;
        for (int i = 0; i < N; i++) begin
          x_q[i] <= win_next[i];
        end
      end
      S_SQL: begin
        sl_q <= $signed(ars.root);
        sc_q <= '0;
      end
      S_SC_WR: begin
        sc_q <= sc_q + 1'b1;
        m_q  <= '0;
      end
      S_SD_WR: begin
        m_q <= m_q + 1'b1;
        n_q <= '0;
      end
      S_ROT_U:  u_q    <= ram_rdata;
      S_ROT_XX: hsum_q <= 64'(p_q);
      S_ROT_H: begin
        h_q <= ars.root;
        if (ars.done && (ars.root == 32'd0)) begin
          c_q <= qrd_pkg::One16;
          s_q <= '0;
        end
      end
      S_ROT_C: if (ars.done) c_q <= sq32;
      S_ROT_S: if (ars.done) s_q <= (xn[31] ^ u_q[31]) ? -sq32 : sq32;
      S_ROT_D1: acc_q <= rm;
      S_ROT_D2: begin
        x_q[n_q] <= '0;
        m_q      <= n_q + 1'b1;
      end
      S_OFF_M0: um_q   <= ram_rdata;
      S_OFF_M1: acc_q  <= rm;
      S_OFF_M2: acc_q  <= acc_q - rm;
      S_OFF_M3: acc2_q <= rm;
      S_OFF_M4: begin
        x_q[m_q] <= qrd_pkg::sat32(acc_q);
        m_q      <= m_q + 1'b1;
      end
      S_RD_M1: acc_q  <= rm;
      S_RD_M2: acc_q  <= acc_q - rm;
      S_RD_M3: acc2_q <= rm;
      S_RD_M4: begin
        d_q   <= qrd_pkg::sat32(acc_q);
        acc_q <= '0;
        m_q   <= '0;
      end
      S_BS_ACC: begin
        acc_q <= acc_q + rm;
        m_q   <= m_q + 1'b1;
      end
      S_BS_DIV: begin
        bs_neg_q <= bs_num[31] ^ bs_den[31];
        if (bs_den == 32'sd0) begin
          n_q   <= n_q + 1'b1;
          acc_q <= '0;
          m_q   <= '0;
        end
      end
      S_BS_WAIT: begin
        if (ars.done) begin
          n_q   <= n_q + 1'b1;
          acc_q <= '0;
          m_q   <= '0;
        end
      end
      S_FIR_ACC: begin
        acc_q <= acc_q + rm;
        m_q   <= m_q + 1'b1;
      end
      S_OUT: begin
        if (out_free) begin
          out_q.filtered_output <= y;
          out_q.error_output    <= qrd_pkg::sat32(64'(des_q) - 64'(y));
        end
      end
      default: begin
        p_q <= mul_a * mul_b;
      end
    endcase
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- src/qrd_chk.sv -----
// port-level checker for the qrd-rls filter, bound to the top level
`default_nettype none
`include "qrd_rls_adaptive_fir_core_defines.svh"

module qrd_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire qrd_pkg::in_beat_t            in_data_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire qrd_pkg::out_beat_t           out_data_o,
  input wire logic                         cfg_we_i,
  input wire logic [qrd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input wire logic [qrd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic in_beat;
  logic unused_cfg;

  assign in_beat    = in_valid_i && in_ready_o;
  assign unused_cfg = cfg_we_i ^ (^cfg_idx_i) ^ (^cfg_wdata_i);

  // a stalled result beat stays put
  `QRD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // restart starts the matrix sweep
  `QRD_ASSERT_NEXT(a_restart_busy, in_beat && in_data_i.op, !in_ready_o)

  // no result can be ready in the cycle after a beat is taken
  `QRD_ASSERT_NEXT(a_no_instant_result, in_beat && !out_valid_o, !out_valid_o)

endmodule

bind qrd_rls_adaptive_fir_core qrd_chk u_qrd_chk (.*);

`default_nettype wire
